// ----- rtl/lhbm_pkg.sv -----
// ---------------------------------------------------------------------------
// lhbm_pkg: shared types and constants of the linear-hash bucket manager
// Field widths, action, status and register codes, and the mask smear.
// ---------------------------------------------------------------------------
`default_nettype none

package lhbm_pkg;

  // field widths
  localparam int ACTION_W  = 3;
  localparam int HASH_W    = 32;
  localparam int SIZE_W    = 32;
  localparam int BUCKET_W  = 32;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int DIV_CNT_W = $clog2(COUNT_W);

  // action codes
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_CHECK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_GROW   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BUCKETS_FULL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_COUNT_FULL   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SIZE_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_COUNT_ZERO   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SIZE_UNDER   = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_FILL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HIGHEST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_RECORDS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DATA    = 2'd3;

  // constants
  localparam logic [31:0]         EXPECTED_FILL_RST = 32'd4000;
  localparam logic [BUCKET_W-1:0] TOP_START         = 32'hFFFF_FFFE;
  localparam logic [BUCKET_W-1:0] BUCKET_LIMIT      = 32'hFFFF_FFFF;

  // copy the top set bit into every lower bit
  function automatic logic [BUCKET_W-1:0] smear(input logic [BUCKET_W-1:0] v);
    logic [BUCKET_W-1:0] s;
    s = v;
    s = s | (s >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    s = s | (s >> 16);
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lhbm_in_if.sv -----
// ---------------------------------------------------------------------------
// lhbm_in_if: request channel of the bucket manager
// Valid/ready handshake carrying one action word.
// ---------------------------------------------------------------------------
`default_nettype none

interface lhbm_in_if;
  logic                          valid;
  logic                          ready;
  logic [lhbm_pkg::ACTION_W-1:0] action;
  logic [lhbm_pkg::HASH_W-1:0]   hash_value;
  logic [lhbm_pkg::SIZE_W-1:0]   record_size;

  modport source (output valid, output action, output hash_value, output record_size,
                  input ready);
  modport sink   (input valid, input action, input hash_value, input record_size,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/lhbm_out_if.sv -----
// ---------------------------------------------------------------------------
// lhbm_out_if: result channel of the bucket manager
// Valid/ready handshake carrying one result word.
// ---------------------------------------------------------------------------
`default_nettype none

interface lhbm_out_if;
  logic                          valid;
  logic                          ready;
  logic [lhbm_pkg::BUCKET_W-1:0] bucket;
  logic                          overfill;
  logic [lhbm_pkg::STATUS_W-1:0] status;
  logic [lhbm_pkg::BUCKET_W-1:0] top_bucket;
  logic [lhbm_pkg::BUCKET_W-1:0] split_bucket;

  modport source (output valid, output bucket, output overfill, output status,
                  output top_bucket, output split_bucket, input ready);
  modport sink   (input valid, input bucket, input overfill, input status,
                  input top_bucket, input split_bucket, output ready);
endinterface

`default_nettype wire

// ----- rtl/lhbm_div.sv -----
// ---------------------------------------------------------------------------
// lhbm_div: dual-lane bit-serial divider
// Two 64-bit dividends over one 32-bit divisor, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module lhbm_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [lhbm_pkg::COUNT_W-1:0]  dividend_a,
  input  wire logic [lhbm_pkg::COUNT_W-1:0]  dividend_b,
  input  wire logic [lhbm_pkg::BUCKET_W-1:0] divisor,
  output logic                              done,
  output logic [lhbm_pkg::COUNT_W-1:0]       quot_a,
  output logic [lhbm_pkg::COUNT_W-1:0]       quot_b
);

  localparam int DW = lhbm_pkg::BUCKET_W;
  localparam int NW = lhbm_pkg::COUNT_W;

  logic                              busy_r;
  logic                              done_r;
  logic [lhbm_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [DW-1:0]                     div_r;
  logic [DW-1:0]                     rem_a_r, rem_b_r;
  logic [NW-1:0]                     q_a_r, q_b_r;

  // restoring step for each lane: shift in the next dividend bit, try subtract
  logic [DW:0] try_a, try_b;
  logic        ge_a, ge_b;
  logic [DW:0] diff_a, diff_b;

  always_comb begin
    try_a  = {rem_a_r, q_a_r[NW-1]};
    try_b  = {rem_b_r, q_b_r[NW-1]};
    ge_a   = try_a >= {1'b0, div_r};
    ge_b   = try_b >= {1'b0, div_r};
    diff_a = try_a - {1'b0, div_r};
    diff_b = try_b - {1'b0, div_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: remainders and dividend/quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      div_r   <= divisor;
      rem_a_r <= '0;
      rem_b_r <= '0;
      q_a_r   <= dividend_a;
      q_b_r   <= dividend_b;
    end else if (busy_r) begin
      rem_a_r <= ge_a ? diff_a[DW-1:0] : try_a[DW-1:0];
      rem_b_r <= ge_b ? diff_b[DW-1:0] : try_b[DW-1:0];
      q_a_r   <= {q_a_r[NW-2:0], ge_a};
      q_b_r   <= {q_b_r[NW-2:0], ge_b};
    end
  end

  assign done   = done_r;
  assign quot_a = q_a_r;
  assign quot_b = q_b_r;

  // the divider is never restarted mid-run and finishes on the last count
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(busy_r) && $past(cnt_r) == '0)
    else $error("divider done without a full run");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");

endmodule

`default_nettype wire

// ----- rtl/linear_hash_bucket_manager.sv -----
// ---------------------------------------------------------------------------
// linear_hash_bucket_manager: linear-hashing bucket address controller
// Keeps highest bucket, mask, split pointer, record count and data size.
// ---------------------------------------------------------------------------
// lookup, add, remove and grow: the word is registered on accept and its result
// is written in the execute state once the output register is free; an overfill
// check first runs the bit-serial divider (64 quotient steps) in the divide state
// a new word is accepted only once the previous result sits in the output register
// reset (synchronous, rst_n low): expected fill 4000, highest bucket 0, mask 1,
// split pointer 0, counts 0, output empty
`default_nettype none

module linear_hash_bucket_manager (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  lhbm_in_if.sink                             in_ch,
  lhbm_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [lhbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lhbm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int BW = lhbm_pkg::BUCKET_W;
  localparam int CW = lhbm_pkg::COUNT_W;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_EXEC} state_t;

  state_t                         state_r;
  logic [lhbm_pkg::ACTION_W-1:0]  act_r;
  logic [lhbm_pkg::HASH_W-1:0]    hash_r;
  logic [lhbm_pkg::SIZE_W-1:0]    size_r;
  logic                           pre_over_r;

  logic [31:0]                    fill_r;
  logic [BW-1:0]                  highest_r, mask_r, split_r;
  logic [CW-1:0]                  records_r, bytes_r;

  logic                           out_valid_r;
  logic [BW-1:0]                  out_bucket_r, out_top_r, out_split_r;
  logic                           out_over_r;
  logic [lhbm_pkg::STATUS_W-1:0]  out_status_r;

  logic                           in_fire, out_free, div_start, div_done;
  logic [CW-1:0]                  quot_a, quot_b;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign div_start   = in_fire && (in_ch.action == lhbm_pkg::ACT_CHECK);

  // overfill operands: data plus record size, records plus one
  logic [CW:0]   chk_sum;
  logic [BW-1:0] top_inc;
  always_comb begin
    chk_sum = {1'b0, bytes_r} + {{(CW + 1 - lhbm_pkg::SIZE_W){1'b0}}, in_ch.record_size};
    top_inc = highest_r + 1'b1;
  end

  lhbm_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .dividend_a (chk_sum[CW-1:0]),
    .dividend_b (records_r + 1'b1),
    .divisor    (top_inc),
    .done       (div_done),
    .quot_a     (quot_a),
    .quot_b     (quot_b)
  );

  // new top loading: from a config write or from growing by one
  logic [BW-1:0] cfg_top, lt_top, lt_inc, lt_mask, lt_split;
  always_comb begin
    cfg_top  = (cfg_data[BW-1:0] > lhbm_pkg::TOP_START) ? lhbm_pkg::TOP_START
                                                        : cfg_data[BW-1:0];
    lt_top   = cfg_we ? cfg_top : top_inc;
    lt_inc   = lt_top + 1'b1;
    lt_mask  = lhbm_pkg::smear(lt_inc);
    lt_split = lt_inc & (lt_mask >> 1);
  end

  // lookup fold
  logic [BW-1:0] lk_raw, lk_bucket;
  always_comb begin
    lk_raw    = hash_r & mask_r;
    lk_bucket = (lk_raw > highest_r) ? (lk_raw & (mask_r >> 1)) : lk_raw;
  end

  // record add and remove arithmetic
  logic [CW:0] add_sum;
  logic        rec_full, rec_zero, rm_under;
  logic [CW-1:0] size_ext;
  always_comb begin
    size_ext = {{(CW - lhbm_pkg::SIZE_W){1'b0}}, size_r};
    add_sum  = {1'b0, bytes_r} + {1'b0, size_ext};
    rec_full = &records_r;
    rec_zero = (records_r == '0);
    rm_under = bytes_r < size_ext;
  end

  // overfill decision from the quotients
  logic [BW+1:0] fill_sum;
  logic          over_calc;
  always_comb begin
    fill_sum  = {2'b00, quot_a[BW-1:0]} + {1'b0, quot_b[BW-1:0], 1'b0};
    over_calc = pre_over_r || (quot_a[CW-1:BW] != '0) || (quot_b[CW-1:BW] != '0) ||
                (fill_sum > {2'b00, fill_r});
  end

  // sequencer, block state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fill_r      <= lhbm_pkg::EXPECTED_FILL_RST;
      highest_r   <= '0;
      mask_r      <= {{(BW - 1){1'b0}}, 1'b1};
      split_r     <= '0;
      records_r   <= '0;
      bytes_r     <= '0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          lhbm_pkg::CFG_EXPECTED_FILL: fill_r <= cfg_data[31:0];
          lhbm_pkg::CFG_START_HIGHEST: begin
            highest_r <= lt_top;
            mask_r    <= lt_mask;
            split_r   <= lt_split;
          end
          lhbm_pkg::CFG_START_RECORDS: records_r <= cfg_data;
          lhbm_pkg::CFG_START_DATA:    bytes_r   <= cfg_data;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            act_r      <= in_ch.action;
            hash_r     <= in_ch.hash_value;
            size_r     <= in_ch.record_size;
            pre_over_r <= chk_sum[CW] || (&records_r);
            state_r    <= div_start ? S_DIV : S_EXEC;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_bucket_r <= '0;
            out_over_r   <= 1'b0;
            out_status_r <= lhbm_pkg::ST_OK;
            out_top_r    <= highest_r;
            out_split_r  <= split_r;
            state_r      <= S_IDLE;
            case (act_r)
              lhbm_pkg::ACT_LOOKUP: out_bucket_r <= lk_bucket;
              lhbm_pkg::ACT_CHECK:  out_over_r   <= over_calc;
              lhbm_pkg::ACT_ADD: begin
                if (rec_full) begin
                  out_status_r <= lhbm_pkg::ST_COUNT_FULL;
                end else if (add_sum[CW]) begin
                  out_status_r <= lhbm_pkg::ST_SIZE_FULL;
                end else begin
                  records_r <= records_r + 1'b1;
                  bytes_r   <= add_sum[CW-1:0];
                end
              end
              lhbm_pkg::ACT_REMOVE: begin
                if (rec_zero) begin
                  out_status_r <= lhbm_pkg::ST_COUNT_ZERO;
                end else if (rm_under) begin
                  out_status_r <= lhbm_pkg::ST_SIZE_UNDER;
                end else begin
                  records_r <= records_r - 1'b1;
                  bytes_r   <= bytes_r - size_ext;
                end
              end
              lhbm_pkg::ACT_GROW: begin
                if (top_inc == lhbm_pkg::BUCKET_LIMIT) begin
                  out_status_r <= lhbm_pkg::ST_BUCKETS_FULL;
                end else begin
                  highest_r    <= lt_top;
                  mask_r       <= lt_mask;
                  split_r      <= lt_split;
                  out_bucket_r <= lt_top;
                  out_top_r    <= lt_top;
                  out_split_r  <= lt_split;
                end
              end
              default: begin
              end
            endcase
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.bucket       = out_bucket_r;
  assign out_ch.overfill     = out_over_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.top_bucket   = out_top_r;
  assign out_ch.split_bucket = out_split_r;

  // table geometry stays consistent and results come only from the execute step
  a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    highest_r != lhbm_pkg::BUCKET_LIMIT) else $error("highest bucket out of range");
  a_split_below_top: assert property (@(posedge clk) disable iff (!rst_n)
    split_r <= highest_r) else $error("split pointer above highest bucket");
  a_mask_covers_top: assert property (@(posedge clk) disable iff (!rst_n)
    (highest_r & ~mask_r) == '0) else $error("mask does not cover highest bucket");
  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EXEC)
    else $error("result word outside execute step");
  a_check_runs_divider: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> state_r == S_DIV) else $error("overfill check skipped divider");

endmodule

`default_nettype wire
